// File: rtl/core/index_linked_list_macros.svh
// ----------------------------------------------------------------------------
// index_linked_list_macros.svh
// Assertion macros shared by the index linked list checker.
// ----------------------------------------------------------------------------
`ifndef INDEX_LINKED_LIST_MACROS_SVH
`define INDEX_LINKED_LIST_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ILL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define ILL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// checks the cycle right after a reset cycle
`define ILL_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ill_pkg.sv
// ----------------------------------------------------------------------------
// ill_pkg
// Types and constants shared by the index linked list block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ill_pkg;

  localparam int unsigned MAX_ITEM = 255;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_GET    = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] item_num;
    logic [7:0] anchor_item;
    logic [7:0] list_position;
  } ill_in_t;

  typedef struct packed {
    logic       modified;
    logic [7:0] found_item;
    logic [7:0] head_item;
    logic [7:0] tail_item;
  } ill_out_t;

  // access to the link memory and member marks
  typedef struct packed {
    logic       link_re;
    logic [7:0] link_rd_addr;
    logic       link_we;
    logic [7:0] link_wr_addr;
    logic [7:0] link_wr_data;
    logic       mark_we;
    logic [7:0] mark_addr;
    logic       mark_wr_val;
  } ill_mem_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_A,
    ST_INS_B,
    ST_INS_C,
    ST_INS_D,
    ST_REM_A,
    ST_REM_B,
    ST_REM_C,
    ST_REM_H,
    ST_GET_A,
    ST_GET_W,
    ST_GET_R,
    ST_CLR_A,
    ST_CLR_W,
    ST_CLR_R,
    ST_FIN
  } ill_state_t;

  function automatic logic item_ok(input logic [7:0] x);
    return (x != 8'd0) && (32'(x) <= MAX_ITEM);
  endfunction

endpackage

// File: rtl/core/ill_store.sv
// ----------------------------------------------------------------------------
// ill_store
// Next-link memory with one read and one write port, member marks with one access port, registered reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ill_store (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ill_pkg::ill_mem_req_t mem_req,
  output logic [7:0]            link_rd_data,
  output logic                  mark_rd_data
);
  import ill_pkg::*;

  logic [7:0]   link_mem [256];
  logic [7:0]   link_rd_r;
  logic [255:0] mark_r;
  logic         mark_rd_r;

  always_ff @(posedge clk) begin
    if (mem_req.link_we) begin
      link_mem[mem_req.link_wr_addr] <= mem_req.link_wr_data;
    end
    if (mem_req.link_re) begin
      link_rd_r <= link_mem[mem_req.link_rd_addr];
    end
  end

  // member marks clear at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= '0;
    end else if (mem_req.mark_we) begin
      mark_r[mem_req.mark_addr] <= mem_req.mark_wr_val;
    end
  end

  always_ff @(posedge clk) begin
    mark_rd_r <= mark_r[mem_req.mark_addr];
  end

  assign link_rd_data = link_rd_r;
  assign mark_rd_data = mark_rd_r;

endmodule

// File: rtl/core/ill_ctrl.sv
// ----------------------------------------------------------------------------
// ill_ctrl
// Request sequencer: steps the link memory through inserts, removes and walks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ill_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ill_pkg::ill_in_t      in_data,
  output ill_pkg::ill_mem_req_t mem_req,
  input  logic [7:0]            link_rd_data,
  input  logic                  mark_rd_data,
  output logic                  res_valid,
  input  logic                  res_ready,
  output ill_pkg::ill_out_t     res_data
);
  import ill_pkg::*;

  ill_state_t state_r, state_nxt;
  logic [1:0] req_r, req_nxt;
  logic [7:0] item_r, item_nxt;
  logic [7:0] anc_r, anc_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] head_r, head_nxt;
  logic [7:0] tail_r, tail_nxt;
  logic [7:0] cur_r, cur_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] victim_r, victim_nxt;
  logic       mod_r, mod_nxt;
  logic [7:0] found_r, found_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= 8'd0;
      tail_r  <= 8'd0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    item_r   <= item_nxt;
    anc_r    <= anc_nxt;
    pos_r    <= pos_nxt;
    cur_r    <= cur_nxt;
    cnt_r    <= cnt_nxt;
    victim_r <= victim_nxt;
    mod_r    <= mod_nxt;
    found_r  <= found_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    item_nxt   = item_r;
    anc_nxt    = anc_r;
    pos_nxt    = pos_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cur_nxt    = cur_r;
    cnt_nxt    = cnt_r;
    victim_nxt = victim_r;
    mod_nxt    = mod_r;
    found_nxt  = found_r;
    mem_req    = '0;
    in_stall   = 1'b1;
    res_valid  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          req_nxt   = in_data.req_type;
          item_nxt  = in_data.item_num;
          anc_nxt   = in_data.anchor_item;
          pos_nxt   = in_data.list_position;
          mod_nxt   = 1'b0;
          found_nxt = 8'd0;
          unique case (in_data.req_type)
            REQ_INSERT: state_nxt = ST_INS_A;
            REQ_REMOVE: state_nxt = ST_REM_A;
            REQ_GET:    state_nxt = ST_GET_A;
            REQ_CLEAR:  state_nxt = ST_CLR_A;
          endcase
        end
      end

      // insert: check the item's mark, then the anchor's mark and link
      ST_INS_A: begin
        mem_req.mark_addr = item_r;
        state_nxt         = ST_INS_B;
      end
      ST_INS_B: begin
        priority if (!item_ok(item_r) || mark_rd_data) begin
          state_nxt = ST_FIN;
        end else if (anc_r == 8'd0) begin
          mem_req.link_we      = 1'b1;
          mem_req.link_wr_addr = item_r;
          mem_req.link_wr_data = head_r;
          mem_req.mark_we      = 1'b1;
          mem_req.mark_addr    = item_r;
          mem_req.mark_wr_val  = 1'b1;
          head_nxt             = item_r;
          if (head_r == 8'd0) begin
            tail_nxt = item_r;
          end
          mod_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end else if (!item_ok(anc_r)) begin
          state_nxt = ST_FIN;
        end else begin
          mem_req.mark_addr    = anc_r;
          mem_req.link_re      = 1'b1;
          mem_req.link_rd_addr = anc_r;
          state_nxt            = ST_INS_C;
        end
      end
      ST_INS_C: begin
        if (!mark_rd_data) begin
          state_nxt = ST_FIN;
        end else begin
          mem_req.link_we      = 1'b1;
          mem_req.link_wr_addr = item_r;
          mem_req.link_wr_data = link_rd_data;
          state_nxt            = ST_INS_D;
        end
      end
      ST_INS_D: begin
        mem_req.link_we      = 1'b1;
        mem_req.link_wr_addr = anc_r;
        mem_req.link_wr_data = item_r;
        mem_req.mark_we      = 1'b1;
        mem_req.mark_addr    = item_r;
        mem_req.mark_wr_val  = 1'b1;
        if (tail_r == anc_r) begin
          tail_nxt = item_r;
        end
        mod_nxt   = 1'b1;
        state_nxt = ST_FIN;
      end

      // remove the successor of the anchor, or the head
      ST_REM_A: begin
        priority if (head_r == 8'd0 || anc_r == tail_r) begin
          state_nxt = ST_FIN;
        end else if (anc_r == 8'd0) begin
          victim_nxt           = head_r;
          mem_req.link_re      = 1'b1;
          mem_req.link_rd_addr = head_r;
          state_nxt            = ST_REM_H;
        end else if (!item_ok(anc_r)) begin
          state_nxt = ST_FIN;
        end else begin
          mem_req.mark_addr    = anc_r;
          mem_req.link_re      = 1'b1;
          mem_req.link_rd_addr = anc_r;
          state_nxt            = ST_REM_B;
        end
      end
      ST_REM_H: begin
        head_nxt            = link_rd_data;
        mem_req.mark_we     = 1'b1;
        mem_req.mark_addr   = victim_r;
        mem_req.mark_wr_val = 1'b0;
        if (tail_r == victim_r) begin
          tail_nxt = 8'd0;
        end
        mod_nxt   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_REM_B: begin
        if (!mark_rd_data) begin
          state_nxt = ST_FIN;
        end else begin
          victim_nxt           = link_rd_data;
          mem_req.link_re      = 1'b1;
          mem_req.link_rd_addr = link_rd_data;
          state_nxt            = ST_REM_C;
        end
      end
      ST_REM_C: begin
        mem_req.link_we      = 1'b1;
        mem_req.link_wr_addr = anc_r;
        mem_req.link_wr_data = link_rd_data;
        mem_req.mark_we      = 1'b1;
        mem_req.mark_addr    = victim_r;
        mem_req.mark_wr_val  = 1'b0;
        if (tail_r == victim_r) begin
          tail_nxt = anc_r;
        end
        mod_nxt   = 1'b1;
        state_nxt = ST_FIN;
      end

      // get: follow links until the position count is reached or the list ends
      ST_GET_A: begin
        if (pos_r == 8'd0) begin
          state_nxt = ST_FIN;
        end else begin
          cur_nxt   = head_r;
          cnt_nxt   = 8'd1;
          state_nxt = ST_GET_W;
        end
      end
      ST_GET_W: begin
        if (cnt_r < pos_r && cur_r != 8'd0) begin
          mem_req.link_re      = 1'b1;
          mem_req.link_rd_addr = cur_r;
          cnt_nxt              = cnt_r + 8'd1;
          state_nxt            = ST_GET_R;
        end else begin
          found_nxt = cur_r;
          state_nxt = ST_FIN;
        end
      end
      ST_GET_R: begin
        cur_nxt   = link_rd_data;
        state_nxt = ST_GET_W;
      end

      // clear: walk the list dropping each member mark
      ST_CLR_A: begin
        mod_nxt   = (head_r != 8'd0);
        cur_nxt   = head_r;
        state_nxt = ST_CLR_W;
      end
      ST_CLR_W: begin
        if (cur_r != 8'd0) begin
          mem_req.link_re      = 1'b1;
          mem_req.link_rd_addr = cur_r;
          mem_req.mark_we      = 1'b1;
          mem_req.mark_addr    = cur_r;
          mem_req.mark_wr_val  = 1'b0;
          state_nxt            = ST_CLR_R;
        end else begin
          head_nxt  = 8'd0;
          tail_nxt  = 8'd0;
          state_nxt = ST_FIN;
        end
      end
      ST_CLR_R: begin
        cur_nxt   = link_rd_data;
        state_nxt = ST_CLR_W;
      end

      ST_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  assign res_data.modified   = mod_r;
  assign res_data.found_item = found_r;
  assign res_data.head_item  = head_r;
  assign res_data.tail_item  = tail_r;

endmodule

// File: rtl/core/index_linked_list.sv
// ----------------------------------------------------------------------------
// index_linked_list: ordered list of item numbers in a next-link memory
// Each link step is a registered read of the link memory. One request at a
// time: the next is taken only after its result has moved into the output
// register, which is held off while out_stall holds an earlier result there.
// Synchronous reset clears control, head, tail and all member marks at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module index_linked_list (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ill_pkg::ill_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ill_pkg::ill_out_t out_data
);
  import ill_pkg::*;

  ill_mem_req_t mem_req;
  logic [7:0]   link_rd_data;
  logic         mark_rd_data;
  logic         res_valid;
  logic         res_ready;
  ill_out_t     res_data;
  logic         out_valid_r;
  ill_out_t     out_data_r;

  ill_store u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .mem_req      (mem_req),
    .link_rd_data (link_rd_data),
    .mark_rd_data (mark_rd_data)
  );

  ill_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .mem_req      (mem_req),
    .link_rd_data (link_rd_data),
    .mark_rd_data (mark_rd_data),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_data     (res_data)
  );

  // output register takes a new result when empty or when not stalled
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/ill_checker.sv
// ----------------------------------------------------------------------------
// ill_checker
// Port-level checks on the index linked list, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "index_linked_list_macros.svh"

module ill_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input ill_pkg::ill_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input ill_pkg::ill_out_t out_data
);
  import ill_pkg::*;

  logic in_wait;
  logic out_wait;
  logic head_empty;
  logic tail_empty;

  assign in_wait    = in_valid && in_stall;
  assign out_wait   = out_valid && out_stall;
  assign head_empty = (out_data.head_item == 8'd0);
  assign tail_empty = (out_data.tail_item == 8'd0);

  `ILL_ASSERT_RST(a_rst_out_idle, !out_valid, "result valid right after reset")

  `ILL_ASSERT_NEXT(a_in_hold, in_wait, in_valid && $stable(in_data), "stalled request changed")

  `ILL_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_data), "stalled result changed")

  `ILL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "sequencer not busy")

  `ILL_ASSERT_NOW(a_head_tail_empty, out_valid, head_empty == tail_empty, "empty flags disagree")

endmodule

bind index_linked_list ill_checker u_ill_checker (.*);
